// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files (included by dense_layer_mac).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("Assertion failed.");
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("Assertion failed.");
`else
`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons)
`define ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

// ===== src/dlm_pkg.sv =====
package dlm_pkg;

	localparam logic OP_FEATURE = 1'b0;
	localparam logic OP_WEIGHT  = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] feature_value;
		logic        [10:0] weight_address;
		logic signed [15:0] weight_value;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] result_value;
		logic        [3:0]  result_index;
		logic               last_of_vector;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

// ===== src/dense_layer_mac.sv =====
// Channel   Direction  Handshake                  Payload
// command   in         start high while busy low  cmd_t
// result    out        result_valid for one cycle res_t
//
// A weight write is a single-cycle transfer and leaves busy low.
// A feature transfer keeps busy high while its weights, and on the last feature of a vector
// the bias row, pass through one weight-store read port feeding one multiplier per cycle.
// Each of the first NEURONS features of a vector returns a result in the cycle after it.
// Reset clears the sequencer, the step and model counters and the result vector.
// The receiver cannot stall results.
`include "assert_macros.svh"

module dense_layer_mac
	import dlm_pkg::*;
#(
	parameter int NEURONS  = 16,
	parameter int FEATURES = 32,
	parameter int MODELS   = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t command,
	output logic result_valid,
	output res_t result
);

	localparam int ROW_WORDS   = NEURONS * (FEATURES + 1);
	localparam int STORE_DEPTH = MODELS * ROW_WORDS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int NIDX_W      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int STEP_W      = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int MOD_W       = (MODELS > 1) ? $clog2(MODELS) : 1;

	state_t state_q, state_d;

	logic signed [15:0] mem [STORE_DEPTH];

	logic [STEP_W-1:0] step_q;
	logic [MOD_W-1:0]  model_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] addr_q;
	logic [NIDX_W-1:0] cnt_q;
	logic              bias_q;
	logic              first_q;
	logic              last_q;
	logic signed [15:0] x_q;

	logic               vld_s1, bias_s1;
	logic [NIDX_W-1:0]  idx_s1;
	logic signed [15:0] rd_s1;
	logic               vld_s2, bias_s2;
	logic [NIDX_W-1:0]  idx_s2;
	logic signed [39:0] prod_s2;
	logic               vld_s3;
	logic [NIDX_W-1:0]  idx_s3;
	logic signed [39:0] sum_s3;

	logic signed [39:0] acc_q [NEURONS];
	logic signed [15:0] rv_q [NEURONS];

	logic               res_vld_q;
	res_t               res_q;

	logic               accept, feat_acc, wr_en, issue, issue_end, step_last;
	logic [31:0]        step_ext, waddr_ext;
	logic signed [31:0] mul;

	function automatic logic signed [15:0] round_sat(input logic signed [39:0] s);
		logic signed [40:0] r;
		logic signed [28:0] q;
		logic signed [15:0] o;
		r = {s[39], s} + 41'sd2048;
		q = r[40:12];
		if (q > 29'sd32767) begin
			o = 16'sh7fff;
		end else if (q < -29'sd32768) begin
			o = 16'sh8000;
		end else begin
			o = q[15:0];
		end
		return o;
	endfunction

	assign accept    = start && !busy;
	assign feat_acc  = accept && (command.opcode == OP_FEATURE);
	assign waddr_ext = 32'(command.weight_address);
	assign wr_en     = accept && (command.opcode == OP_WEIGHT) && (waddr_ext < STORE_DEPTH);
	assign step_ext  = 32'(step_q);
	assign step_last = (step_ext == FEATURES - 1);
	assign issue     = (state_q == ST_RUN);
	assign issue_end = (32'(cnt_q) == NEURONS - 1) && !(last_q && !bias_q);
	assign busy      = (state_q != ST_IDLE);
	assign mul       = rd_s1 * x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (feat_acc) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (issue_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!(vld_s1 || vld_s2 || vld_s3)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr_ext[ADDR_W-1:0]] <= command.weight_value;
		if (issue) rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			model_q <= '0;
			base_q  <= '0;
			cnt_q   <= '0;
			bias_q  <= 1'b0;
			first_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (feat_acc) begin
			cnt_q   <= '0;
			bias_q  <= 1'b0;
			first_q <= (step_ext == 0);
			last_q  <= step_last;
			if (step_last) begin
				step_q <= '0;
				if (32'(model_q) == MODELS - 1) begin
					model_q <= '0;
					base_q  <= '0;
				end else begin
					model_q <= model_q + 1'b1;
					base_q  <= base_q + ADDR_W'(ROW_WORDS);
				end
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else if (issue) begin
			if (32'(cnt_q) == NEURONS - 1) begin
				cnt_q  <= '0;
				bias_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// The bias row follows the last weight row, so the address just keeps counting.
	always_ff @(posedge clk) begin
		if (feat_acc) begin
			x_q    <= command.feature_value;
			addr_q <= base_q + ADDR_W'(step_ext * NEURONS);
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && bias_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q;
		bias_s1 <= bias_q;
		idx_s2  <= idx_s1;
		bias_s2 <= bias_s1;
		if (bias_s1) begin
			prod_s2 <= {{12{rd_s1[15]}}, rd_s1, 12'b0};
		end else begin
			prod_s2 <= {{8{mul[31]}}, mul};
		end
		idx_s3 <= idx_s2;
		sum_s3 <= acc_q[idx_s2] + prod_s2;
		if (vld_s2 && !bias_s2) begin
			if (first_q) begin
				acc_q[idx_s2] <= prod_s2;
			end else begin
				acc_q[idx_s2] <= acc_q[idx_s2] + prod_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NEURONS; i++) rv_q[i] <= '0;
		end else if (vld_s3) begin
			rv_q[idx_s3] <= round_sat(sum_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= feat_acc && (step_ext < NEURONS);
		end
	end

	always_ff @(posedge clk) begin
		if (feat_acc) begin
			res_q.result_value   <= rv_q[step_ext[NIDX_W-1:0]];
			res_q.result_index   <= step_ext[3:0];
			res_q.last_of_vector <= (step_ext == NEURONS - 1);
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	`ASSERT_IMPLIES(a_res_after_feature, clk, arst_n, result_valid, $past(feat_acc))
	`ASSERT_IMPLIES(a_idle_drained, clk, arst_n, state_q == ST_IDLE, !(vld_s1 || vld_s2 || vld_s3))
	`ASSERT_NEXT(a_weight_single_cycle, clk, arst_n, accept && !feat_acc, !busy)
	`ASSERT_IMPLIES(a_bias_on_last, clk, arst_n, vld_s2 && bias_s2, last_q)

endmodule
